[rtl/rsts_pkg.sv]
// Shared types and constants for the rotated sorted table search block.
// No dependencies; the top level, rsts_ctrl and rsts_dp import this package.
package rsts_pkg;

  localparam int unsigned DepthDef      = 1024;
  localparam int unsigned ValueWidthDef = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_ML,
    ST_READ_H,
    ST_DECIDE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // write one table entry
    logic init;         // latch key, open the search range
    logic issue_ml;     // read entries at mid and lo
    logic issue_h;      // read entry at hi, hold mid and lo values
    logic step;         // narrow the range
    logic finish_hit;   // post a found result
    logic finish_miss;  // post a not-found result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;  // no entries in use
    logic hit;    // entry at mid equals the key
    logic stop;   // the chosen half is empty
  } stat_t;

endpackage

[rtl/rotated_sorted_table_search_top.sv]
// Top level of the rotated sorted table search: controller plus datapath.
// Depends on rsts_pkg, rsts_ctrl, rsts_dp (which holds rsts_ram).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  command  | start / busy           | operation_i, entry_index_i, entry_value_i,
//           |                        | key_i
//  result   | result_valid_o strobe  | found_o, position_o
//  config   | cfg_we_i               | cfg_wdata_i (entry count)
//
// A load word writes the table at the edge where it is taken; busy never
// rises for it. A query word runs each probe through read mid and lo on the
// two RAM ports, read hi and decide, a hit ending its probe in the read-hi
// state before hi is read, with at most ceil(log2(count+1)) probes; the result
// strobe is registered from the last probe and comes in the cycle where busy
// drops. An empty table answers from idle without a probe; busy never rises.
// Reset clears the controller, the entry count and the strobe; the table
// holds no reset value and needs no clearing pass. The receiver cannot stall.
module rotated_sorted_table_search_top #(
  parameter int unsigned DEPTH       = rsts_pkg::DepthDef,
  parameter int unsigned VALUE_WIDTH = rsts_pkg::ValueWidthDef,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [IdxW-1:0]               entry_index_i,
  input  logic signed [VALUE_WIDTH-1:0] entry_value_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic                          cfg_we_i,
  input  logic [CntW-1:0]               cfg_wdata_i,
  output logic                          result_valid_o,
  output logic                          found_o,
  output logic [IdxW-1:0]               position_o
);
  import rsts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing: idle, read mid/lo, read hi, decide; loop until hit or empty.
  rsts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // Range registers, comparisons, table RAM and result registers.
  rsts_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .key_i          (key_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .position_o     (position_o)
  );

endmodule

[rtl/rsts_ram.sv]
// Generic RAM: one write/read port, one read-only port, registered read data.
// No dependencies.
module rsts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             a_we_i,
  input  logic             a_re_i,
  input  logic [AddrW-1:0] a_addr_i,
  input  logic [WIDTH-1:0] a_wdata_i,
  output logic [WIDTH-1:0] a_rdata_o,
  input  logic             b_re_i,
  input  logic [AddrW-1:0] b_addr_i,
  output logic [WIDTH-1:0] b_rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] a_rdata_q;
  logic [WIDTH-1:0] b_rdata_q;

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      mem_q[a_addr_i] <= a_wdata_i;
    end else if (a_re_i) begin
      a_rdata_q <= mem_q[a_addr_i];
    end
    if (b_re_i) begin
      b_rdata_q <= mem_q[b_addr_i];
    end
  end

  assign a_rdata_o = a_rdata_q;
  assign b_rdata_o = b_rdata_q;

endmodule

[rtl/rsts_ctrl.sv]
// Controller state machine for the rotated sorted table search.
// Depends on rsts_pkg (state enum, command and status structs).
module rsts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           operation_i,
  input  rsts_pkg::stat_t stat_i,
  output rsts_pkg::cmd_t  cmd_o,
  output logic           busy
);
  import rsts_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (operation_i == OpLoad) begin
            cmd_o.load = 1'b1;
          end else if (stat_i.empty) begin
            cmd_o.finish_miss = 1'b1;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = ST_READ_ML;
          end
        end
      end
      ST_READ_ML: begin
        cmd_o.issue_ml = 1'b1;
        state_d        = ST_READ_H;
      end
      ST_READ_H: begin
        if (stat_i.hit) begin
          cmd_o.finish_hit = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.issue_h = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.stop) begin
          cmd_o.finish_miss = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_READ_ML;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // A result posts only from idle on an empty table or at the end of a probe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish_hit |-> $past(cmd_o.issue_ml))
    else $error("hit posted without a preceding mid read");
  // A probe always follows a range init or a narrowing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue_ml |-> ($past(cmd_o.init) || $past(cmd_o.step)))
    else $error("probe started without an open range");
  // Loads are only taken while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (start && !busy))
    else $error("load outside of an accepted word");

endmodule

[rtl/rsts_dp.sv]
// Datapath for the rotated sorted table search: range registers, compare
// logic, result registers and the table RAM. Depends on rsts_pkg, rsts_ram.
module rsts_dp #(
  parameter int unsigned DEPTH       = rsts_pkg::DepthDef,
  parameter int unsigned VALUE_WIDTH = rsts_pkg::ValueWidthDef,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsts_pkg::cmd_t                cmd_i,
  output rsts_pkg::stat_t               stat_o,
  input  logic                          cfg_we_i,
  input  logic [CntW-1:0]               cfg_wdata_i,
  input  logic [IdxW-1:0]               entry_index_i,
  input  logic signed [VALUE_WIDTH-1:0] entry_value_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  output logic                          result_valid_o,
  output logic                          found_o,
  output logic [IdxW-1:0]               position_o
);
  import rsts_pkg::*;

  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [CntW-1:0]               count_q;
  logic [CntW-1:0]               n_clamp;
  logic [CntW-1:0]               n_m1;
  logic signed [VALUE_WIDTH-1:0] key_q, vm_q, vl_q;
  logic [IdxW-1:0]               lo_q, hi_q, mid_q;
  logic [IdxW:0]                 mid_sum;
  logic [IdxW-1:0]               mid_c;
  logic                          done_q, found_q;
  logic [IdxW-1:0]               position_q;
  logic [VALUE_WIDTH-1:0]        a_rdata, b_rdata;
  logic signed [VALUE_WIDTH-1:0] vh;
  logic [IdxW-1:0]               a_addr;
  logic                          in_range;
  logic                          go_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign n_clamp      = (count_q > DepthC) ? DepthC : count_q;
  assign n_m1         = n_clamp - CntW'(1);
  assign stat_o.empty = (n_clamp == '0);

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[IdxW:1];

  assign vh          = $signed(a_rdata);
  assign stat_o.hit  = ($signed(a_rdata) == key_q);

  // Pick the half that can still hold the key.
  always_comb begin
    if (vl_q <= vm_q) begin
      go_left = (key_q >= vl_q) && (key_q < vm_q);
    end else begin
      go_left = !((key_q > vm_q) && (key_q <= vh));
    end
  end

  assign stat_o.stop = go_left ? (mid_q == lo_q) : (mid_q == hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      key_q <= key_i;
      lo_q  <= '0;
      hi_q  <= n_m1[IdxW-1:0];
    end
    if (cmd_i.issue_ml) begin
      mid_q <= mid_c;
    end
    if (cmd_i.issue_h) begin
      vm_q <= $signed(a_rdata);
      vl_q <= $signed(b_rdata);
    end
    if (cmd_i.step) begin
      if (go_left) begin
        hi_q <= mid_q - IdxW'(1);
      end else begin
        lo_q <= mid_q + IdxW'(1);
      end
    end
    if (cmd_i.finish_hit) begin
      found_q    <= 1'b1;
      position_q <= mid_q;
    end else if (cmd_i.finish_miss) begin
      found_q    <= 1'b0;
      position_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish_hit | cmd_i.finish_miss;
    end
  end

  assign in_range = (CntW'(entry_index_i) < DepthC);

  always_comb begin
    if (cmd_i.load) begin
      a_addr = entry_index_i;
    end else if (cmd_i.issue_ml) begin
      a_addr = mid_c;
    end else begin
      a_addr = hi_q;
    end
  end

  rsts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .a_we_i    (cmd_i.load & in_range),
    .a_re_i    (cmd_i.issue_ml | cmd_i.issue_h),
    .a_addr_i  (a_addr),
    .a_wdata_i (entry_value_i),
    .a_rdata_o (a_rdata),
    .b_re_i    (cmd_i.issue_ml),
    .b_addr_i  (lo_q),
    .b_rdata_o (b_rdata)
  );

  assign result_valid_o = done_q;
  assign found_o        = found_q;
  assign position_o     = position_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_ml |-> (lo_q <= hi_q))
    else $error("probe on an empty range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !stat_o.stop)
    else $error("narrowing step past the end of the range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !found_q) |-> (position_q == '0))
    else $error("not-found result carries a nonzero position");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.init, cmd_i.issue_ml, cmd_i.issue_h,
              cmd_i.step, cmd_i.finish_hit, cmd_i.finish_miss}))
    else $error("more than one datapath command at once");

endmodule
